// ----- rtl/cdt_pkg.sv -----
`default_nettype none

package cdt_pkg;

   localparam int unsigned MAX_SET_SECONDS = 59940;

   localparam int unsigned STEP_W    = 12;
   localparam int unsigned HOLD_W    = 8;
   localparam int unsigned SET_W     = 16;
   localparam int unsigned ELAPSED_W = 16;
   localparam int unsigned PROD_W    = 32;
   localparam int unsigned OP_W      = 3;
   localparam int unsigned SUBSEC_W  = 4;
   localparam int unsigned MODE_W    = 3;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned MSG_W     = 2;

   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned CSR_ADDR_W = 1;
   localparam int unsigned CSR_DATA_W = STEP_W;

   // modes
   localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SET   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CD    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PAUSE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STAT  = 3'd4;

   // event kinds
   localparam logic [OP_W-1:0] OP_INC   = 3'd0;
   localparam logic [OP_W-1:0] OP_DEC   = 3'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 3'd2;
   localparam logic [OP_W-1:0] OP_START = 3'd3;
   localparam logic [OP_W-1:0] OP_ABORT = 3'd4;

   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_HANDLED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TRANS   = 2'd2;

   localparam logic [MSG_W-1:0] MSG_NONE   = 2'd0;
   localparam logic [MSG_W-1:0] MSG_SET    = 2'd1;
   localparam logic [MSG_W-1:0] MSG_PAUSED = 2'd2;
   localparam logic [MSG_W-1:0] MSG_PROD   = 2'd3;

   localparam logic [SUBSEC_W-1:0] SUBSEC_BEEP = 4'd5;
   localparam logic [SUBSEC_W-1:0] SUBSEC_FULL = 4'd10;

   localparam logic [CSR_ADDR_W-1:0] CSR_TIME_STEP  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STAT_HOLD  = 1'd1;

   localparam logic [STEP_W-1:0] TIME_STEP_RESET = 12'd60;
   localparam logic [HOLD_W-1:0] STAT_HOLD_RESET = 8'd30;

   typedef struct packed {
      logic [5:0]          pad;
      logic                beep;
      logic                clear_display;
      logic [MSG_W-1:0]    message;
      logic                time_shown;
      logic [PROD_W-1:0]   shown_time;
      logic [MODE_W-1:0]   mode;
      logic [STATUS_W-1:0] event_status;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/countdown_timer_with_pause_stats.sv -----
// Five-mode countdown timer (idle, set, countdown, pause, statistics).
// req channel: one event per beat; req_tuser carries the event kind,
// req_tdata the tenth-of-second count of a tick.
// rsp channel: exactly one result beat per event, carrying status, mode
// after the event, displayed time and flag, message code, clear and beep.
// csr port: csr_we writes time_step (index 0) or stat_hold_ticks (index 1)
// at the clock edge; write only while no event is in flight.
// The result is in the output register in the cycle after the event beat
// is taken. Throughput: one event per cycle, limited only by the
// single output register.
// The output register may hold a finished result while the next event is
// taken in the same cycle that the receiver takes it; while the receiver
// stalls with a result waiting, req_tready is low.
// Synchronous reset returns to idle with all counters zero and the
// registers at time_step 60, stat_hold_ticks 30; no entry action runs and
// no result is produced until the first event.
`default_nettype none

module countdown_timer_with_pause_stats (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [cdt_pkg::REQ_DATA_W-1:0]    req_tdata,  // sub_second, zero pad
   input  wire logic [cdt_pkg::OP_W-1:0]          req_tuser,  // operation
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // event_status, mode, shown_time, time_shown, message, clear_display, beep, zero pad
   output      logic [cdt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [cdt_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [cdt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [cdt_pkg::STEP_W-1:0]    time_step_ff;
   logic [cdt_pkg::HOLD_W-1:0]    stat_hold_ff;
   logic [cdt_pkg::MODE_W-1:0]    mode_ff, mode_in, next_mode;
   logic [cdt_pkg::SET_W-1:0]     set_ff, set_in;
   logic [cdt_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [cdt_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [cdt_pkg::HOLD_W-1:0]    stat_cnt_ff, stat_cnt_in;
   logic                          rsp_valid_ff;
   cdt_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          req_fire;
   logic [cdt_pkg::OP_W-1:0]      op;
   logic [cdt_pkg::SUBSEC_W-1:0]  sub_sec;
   logic [cdt_pkg::SET_W:0]       add_sum;
   logic [cdt_pkg::SET_W-1:0]     add_sat;
   logic                          sub_ok;
   logic [cdt_pkg::SET_W-1:0]     sub_val;
   logic [cdt_pkg::SET_W-1:0]     cd_set;
   logic [cdt_pkg::ELAPSED_W-1:0] elapsed_inc;
   logic [cdt_pkg::PROD_W:0]      prod_sum;
   logic [cdt_pkg::PROD_W-1:0]    prod_sat;
   logic [cdt_pkg::HOLD_W-1:0]    stat_cnt_inc;
   logic                          trans;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign op         = req_tuser;
   assign sub_sec    = req_tdata[cdt_pkg::SUBSEC_W-1:0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // shared arithmetic
   always_comb begin
      add_sum = {1'b0, set_ff} + (cdt_pkg::SET_W+1)'(time_step_ff);
      add_sat = (add_sum > (cdt_pkg::SET_W+1)'(cdt_pkg::MAX_SET_SECONDS)) ?
                cdt_pkg::SET_W'(cdt_pkg::MAX_SET_SECONDS) : add_sum[cdt_pkg::SET_W-1:0];
      sub_ok  = set_ff >= cdt_pkg::SET_W'(time_step_ff);
      sub_val = set_ff - cdt_pkg::SET_W'(time_step_ff);
      cd_set  = (set_ff != '0) ? set_ff - 1'b1 : '0;
      elapsed_inc = (elapsed_ff != '1) ? elapsed_ff + 1'b1 : elapsed_ff;
      // a countdown tick that runs out counts its own second
      prod_sum = {1'b0, prod_ff} + (cdt_pkg::PROD_W+1)'((op == cdt_pkg::OP_TICK) ?
                 elapsed_inc : elapsed_ff);
      prod_sat = prod_sum[cdt_pkg::PROD_W] ? '1 : prod_sum[cdt_pkg::PROD_W-1:0];
      stat_cnt_inc = stat_cnt_ff + 1'b1;
   end

   // event dispatch, exit and entry actions
   always_comb begin
      set_in      = set_ff;
      elapsed_in  = elapsed_ff;
      prod_in     = prod_ff;
      stat_cnt_in = stat_cnt_ff;
      next_mode   = mode_ff;
      trans       = 1'b0;
      rsp_in      = '0;
      rsp_in.event_status = cdt_pkg::ST_IGNORED;

      unique case (mode_ff)
         cdt_pkg::MODE_IDLE: begin
            if (op == cdt_pkg::OP_INC) begin
               set_in    = add_sat;
               next_mode = cdt_pkg::MODE_SET;
               trans     = 1'b1;
            end else if (op == cdt_pkg::OP_START) begin
               next_mode = cdt_pkg::MODE_STAT;
               trans     = 1'b1;
            end else if (op == cdt_pkg::OP_TICK && sub_sec == cdt_pkg::SUBSEC_BEEP) begin
               rsp_in.beep         = 1'b1;
               rsp_in.event_status = cdt_pkg::ST_HANDLED;
            end
         end
         cdt_pkg::MODE_SET: begin
            if (op == cdt_pkg::OP_ABORT) begin
               next_mode = cdt_pkg::MODE_IDLE;
               trans     = 1'b1;
            end else if (op == cdt_pkg::OP_INC) begin
               set_in              = add_sat;
               rsp_in.time_shown   = 1'b1;
               rsp_in.shown_time   = cdt_pkg::PROD_W'(add_sat);
               rsp_in.event_status = cdt_pkg::ST_HANDLED;
            end else if (op == cdt_pkg::OP_DEC) begin
               if (sub_ok) begin
                  set_in              = sub_val;
                  rsp_in.time_shown   = 1'b1;
                  rsp_in.shown_time   = cdt_pkg::PROD_W'(sub_val);
                  rsp_in.event_status = cdt_pkg::ST_HANDLED;
               end
            end else if (op == cdt_pkg::OP_START) begin
               if (sub_ok && set_ff != '0) begin
                  next_mode = cdt_pkg::MODE_CD;
                  trans     = 1'b1;
               end
            end
         end
         cdt_pkg::MODE_CD: begin
            if (op == cdt_pkg::OP_TICK) begin
               if (sub_sec == cdt_pkg::SUBSEC_FULL) begin
                  set_in            = cd_set;
                  elapsed_in        = elapsed_inc;
                  rsp_in.time_shown = 1'b1;
                  rsp_in.shown_time = cdt_pkg::PROD_W'(cd_set);
                  if (cd_set == '0) begin
                     next_mode = cdt_pkg::MODE_IDLE;
                     trans     = 1'b1;
                  end else begin
                     rsp_in.event_status = cdt_pkg::ST_HANDLED;
                  end
               end
            end else if (op == cdt_pkg::OP_ABORT) begin
               next_mode = cdt_pkg::MODE_IDLE;
               trans     = 1'b1;
            end else if (op == cdt_pkg::OP_START) begin
               next_mode = cdt_pkg::MODE_PAUSE;
               trans     = 1'b1;
            end
         end
         cdt_pkg::MODE_PAUSE: begin
            if (op == cdt_pkg::OP_START) begin
               next_mode = cdt_pkg::MODE_CD;
               trans     = 1'b1;
            end else if (op == cdt_pkg::OP_INC) begin
               set_in    = add_sat;
               next_mode = cdt_pkg::MODE_SET;
               trans     = 1'b1;
            end else if (op == cdt_pkg::OP_DEC) begin
               if (sub_ok) begin
                  set_in    = sub_val;
                  next_mode = cdt_pkg::MODE_SET;
                  trans     = 1'b1;
               end
            end else if (op == cdt_pkg::OP_ABORT) begin
               next_mode = cdt_pkg::MODE_IDLE;
               trans     = 1'b1;
            end
         end
         default: begin
            if (op == cdt_pkg::OP_TICK) begin
               stat_cnt_in = stat_cnt_inc;
               if (stat_cnt_inc == stat_hold_ff) begin
                  stat_cnt_in = '0;
                  next_mode   = cdt_pkg::MODE_IDLE;
                  trans       = 1'b1;
               end
            end
         end
      endcase

      if (trans) begin
         rsp_in.event_status = cdt_pkg::ST_TRANS;
         // exit action of the old mode
         if (mode_ff == cdt_pkg::MODE_CD) begin
            prod_in    = prod_sat;
            elapsed_in = '0;
         end else begin
            rsp_in.clear_display = 1'b1;
            rsp_in.time_shown    = 1'b0;
            rsp_in.shown_time    = '0;
            rsp_in.message       = cdt_pkg::MSG_NONE;
         end
         // entry action of the new mode
         unique case (next_mode)
            cdt_pkg::MODE_IDLE: begin
               set_in            = '0;
               elapsed_in        = '0;
               rsp_in.time_shown = 1'b1;
               rsp_in.shown_time = '0;
               rsp_in.message    = cdt_pkg::MSG_SET;
            end
            cdt_pkg::MODE_SET: begin
               rsp_in.time_shown = 1'b1;
               rsp_in.shown_time = cdt_pkg::PROD_W'(set_in);
            end
            cdt_pkg::MODE_PAUSE: begin
               rsp_in.message = cdt_pkg::MSG_PAUSED;
            end
            cdt_pkg::MODE_STAT: begin
               rsp_in.time_shown = 1'b1;
               rsp_in.shown_time = prod_in;
               rsp_in.message    = cdt_pkg::MSG_PROD;
            end
            default: begin
            end
         endcase
      end

      mode_in     = next_mode;
      rsp_in.mode = next_mode;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= cdt_pkg::TIME_STEP_RESET;
         stat_hold_ff <= cdt_pkg::STAT_HOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            cdt_pkg::CSR_TIME_STEP: time_step_ff <= csr_wdata;
            cdt_pkg::CSR_STAT_HOLD: stat_hold_ff <= csr_wdata[cdt_pkg::HOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= cdt_pkg::MODE_IDLE;
         set_ff      <= '0;
         elapsed_ff  <= '0;
         prod_ff     <= '0;
         stat_cnt_ff <= '0;
      end else if (req_fire) begin
         mode_ff     <= mode_in;
         set_ff      <= set_in;
         elapsed_ff  <= elapsed_in;
         prod_ff     <= prod_in;
         stat_cnt_ff <= stat_cnt_in;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef ASSERT_OFF
   a_set_max: assert property (@(posedge clock) disable iff (reset)
      set_ff <= cdt_pkg::SET_W'(cdt_pkg::MAX_SET_SECONDS))
      else $error("set time above maximum");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (req_fire && trans && next_mode == cdt_pkg::MODE_IDLE)
      |=> (set_ff == '0 && elapsed_ff == '0))
      else $error("idle entry left time counters nonzero");

   a_clear_trans: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.clear_display) |-> (rsp_ff.event_status == cdt_pkg::ST_TRANS))
      else $error("display cleared without a transition");

   a_beep_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.beep)
      |-> (rsp_ff.mode == cdt_pkg::MODE_IDLE && rsp_ff.event_status == cdt_pkg::ST_HANDLED))
      else $error("beep outside idle");

   a_mode_match: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_ff.mode == mode_ff))
      else $error("reported mode differs from state");
`endif

endmodule

`default_nettype wire
